// ===== hdl/ear_pkg.sv =====
// Shared types, constants and helper functions for the Euler-angle rotation matrix block.
package ear_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int AtanLen            = 24;

   localparam logic signed [33:0] InvGain = 34'sd652032874;
   localparam logic signed [34:0] HalfPi  = 35'sd1686629713;
   localparam logic signed [34:0] Pi      = 35'sd3373259426;
   localparam logic signed [19:0] OneQ14  = 20'sd16384;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
   } ear_req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } ear_rsp_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } ear_lane_type;

   typedef struct packed {
      logic                   valid;
      logic                   kind;
      logic [2:0]             flip;
      ear_lane_type [2:0]     lane;
   } ear_pipe_type;

   typedef struct packed {
      logic               valid;
      logic               kind;
      logic signed [15:0] sx;
      logic signed [15:0] cx;
      logic signed [15:0] sy;
      logic signed [15:0] cy;
      logic signed [15:0] sz;
      logic signed [15:0] cz;
   } ear_trig_type;

   function automatic logic signed [33:0] ear_atan(input int idx);
      logic signed [33:0] a;
      case (idx)
         0:  a = 34'sd843314857;
         1:  a = 34'sd497837829;
         2:  a = 34'sd263043837;
         3:  a = 34'sd133525159;
         4:  a = 34'sd67021687;
         5:  a = 34'sd33543516;
         6:  a = 34'sd16775851;
         7:  a = 34'sd8388437;
         8:  a = 34'sd4194283;
         9:  a = 34'sd2097149;
         10: a = 34'sd1048576;
         11: a = 34'sd524288;
         12: a = 34'sd262144;
         13: a = 34'sd131072;
         14: a = 34'sd65536;
         15: a = 34'sd32768;
         16: a = 34'sd16384;
         17: a = 34'sd8192;
         18: a = 34'sd4096;
         19: a = 34'sd2048;
         20: a = 34'sd1024;
         21: a = 34'sd512;
         22: a = 34'sd256;
         23: a = 34'sd128;
         default: a = 34'sd0;
      endcase
      return a;
   endfunction

   // Saturate a Q2.14 value to [-1, +1].
   function automatic logic signed [15:0] ear_clamp(input logic signed [19:0] v);
      logic signed [19:0] r;
      if (v > OneQ14) begin
         r = OneQ14;
      end else if (v < -OneQ14) begin
         r = -OneQ14;
      end else begin
         r = v;
      end
      return r[15:0];
   endfunction

endpackage

// ===== hdl/ear_cordic_cell.sv =====
// One CORDIC rotation step for the three angle lanes, registered.
module ear_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ear_pkg::ear_pipe_type prev_stage,
   output ear_pkg::ear_pipe_type next_stage
);

   localparam logic signed [33:0] ATAN = ear_pkg::ear_atan(STEP);

   ear_pkg::ear_pipe_type cell_ff, cell_in;
   logic signed [33:0]    dx [3];
   logic signed [33:0]    dy [3];

   always_comb begin
      cell_in = prev_stage;
      for (int l = 0; l < 3; l++) begin
         dx[l] = prev_stage.lane[l].y >>> STEP;
         dy[l] = prev_stage.lane[l].x >>> STEP;
         if (!prev_stage.lane[l].z[33]) begin
            cell_in.lane[l].x = prev_stage.lane[l].x - dx[l];
            cell_in.lane[l].y = prev_stage.lane[l].y + dy[l];
            cell_in.lane[l].z = prev_stage.lane[l].z - ATAN;
         end else begin
            cell_in.lane[l].x = prev_stage.lane[l].x + dx[l];
            cell_in.lane[l].y = prev_stage.lane[l].y - dy[l];
            cell_in.lane[l].z = prev_stage.lane[l].z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign next_stage = cell_ff;

endmodule

// ===== hdl/ear_matrix.sv =====
// Three-stage matrix assembly: pair products, triple products, sum and round.
module ear_matrix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            advance,
   input  ear_pkg::ear_trig_type trig,
   output logic [2:0]            valid,
   output ear_pkg::ear_rsp_type  rsp
);

   localparam int CyCz = 0;
   localparam int CySz = 1;
   localparam int CxSz = 2;
   localparam int CxCz = 3;
   localparam int CySx = 4;
   localparam int SxSz = 5;
   localparam int CzSx = 6;
   localparam int CxCy = 7;

   // triple slots: pair times sy
   localparam int TSxSz = 0;
   localparam int TCxCz = 1;
   localparam int TCzSx = 2;
   localparam int TCxSz = 3;

   logic               v1_ff, v2_ff, v3_ff;
   logic               kind1_ff, kind2_ff;
   logic signed [15:0] sy1_ff, sy2_ff;
   logic signed [31:0] pair1_ff [8];
   logic signed [31:0] pair2_ff [8];
   logic signed [47:0] tri2_ff  [4];
   ear_pkg::ear_rsp_type rsp_ff, rsp_in;

   logic signed [47:0] q [8];
   logic signed [47:0] qsy;
   logic signed [47:0] sum [9];
   logic signed [47:0] rnd [9];
   logic signed [15:0] m   [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance[0]) begin
         v1_ff <= trig.valid;
      end
      if (advance[0]) begin
         kind1_ff       <= trig.kind;
         sy1_ff         <= trig.sy;
         pair1_ff[CyCz] <= 32'(trig.cy * trig.cz);
         pair1_ff[CySz] <= 32'(trig.cy * trig.sz);
         pair1_ff[CxSz] <= 32'(trig.cx * trig.sz);
         pair1_ff[CxCz] <= 32'(trig.cx * trig.cz);
         pair1_ff[CySx] <= 32'(trig.cy * trig.sx);
         pair1_ff[SxSz] <= 32'(trig.sx * trig.sz);
         pair1_ff[CzSx] <= 32'(trig.cz * trig.sx);
         pair1_ff[CxCy] <= 32'(trig.cx * trig.cy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance[1]) begin
         v2_ff <= v1_ff;
      end
      if (advance[1]) begin
         kind2_ff      <= kind1_ff;
         sy2_ff        <= sy1_ff;
         pair2_ff      <= pair1_ff;
         tri2_ff[TSxSz] <= 48'(pair1_ff[SxSz] * sy1_ff);
         tri2_ff[TCxCz] <= 48'(pair1_ff[CxCz] * sy1_ff);
         tri2_ff[TCzSx] <= 48'(pair1_ff[CzSx] * sy1_ff);
         tri2_ff[TCxSz] <= 48'(pair1_ff[CxSz] * sy1_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         q[i] = {{2{pair2_ff[i][31]}}, pair2_ff[i], 14'b0};
      end
      qsy = {{4{sy2_ff[15]}}, sy2_ff, 28'b0};
      if (!kind2_ff) begin
         sum[0] = q[CyCz];
         sum[1] = -q[CySz];
         sum[2] = qsy;
         sum[3] = q[CxSz] + tri2_ff[TCzSx];
         sum[4] = q[CxCz] - tri2_ff[TSxSz];
         sum[5] = -q[CySx];
         sum[6] = q[SxSz] - tri2_ff[TCxCz];
         sum[7] = q[CzSx] + tri2_ff[TCxSz];
         sum[8] = q[CxCy];
      end else begin
         sum[0] = q[CyCz];
         sum[1] = tri2_ff[TCzSx] - q[CxSz];
         sum[2] = q[SxSz] + tri2_ff[TCxCz];
         sum[3] = q[CySz];
         sum[4] = q[CxCz] + tri2_ff[TSxSz];
         sum[5] = tri2_ff[TCxSz] - q[CzSx];
         sum[6] = -qsy;
         sum[7] = q[CySx];
         sum[8] = q[CxCy];
      end
      for (int i = 0; i < 9; i++) begin
         rnd[i] = (sum[i] + 48'sd134217728) >>> 28;
         m[i]   = ear_pkg::ear_clamp(rnd[i][19:0]);
      end
      rsp_in = '{m00: m[0], m01: m[1], m02: m[2], m10: m[3], m11: m[4],
                 m12: m[5], m20: m[6], m21: m[7], m22: m[8]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance[2]) begin
         v3_ff <= v2_ff;
      end
      if (advance[2]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign valid = {v3_ff, v2_ff, v1_ff};
   assign rsp   = rsp_ff;

endmodule

// ===== hdl/euler_angles_to_rotation_matrix.sv =====
// Top level: Euler angles to 3x3 rotation matrix, fully pipelined.
//
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries one transaction:
//   order select kind plus three Q3.13 angles. Response channel (rsp_valid /
//   rsp_stall / rsp_data) returns the nine Q2.14 matrix entries, one response
//   per request, in request order.
//   Stages from acceptance to rsp_valid: one fold stage, one CORDIC cell
//   per step (capped at 24), one sine/cosine rounding stage, and three
//   matrix stages (pair products, triple products, sum/round into the
//   output register).
//   Throughput is one transaction per cycle while rsp_stall is low.
//   Each stage holds a valid bit and advances whenever the stage after it is
//   empty or advancing, so bubbles collapse while the output is stalled and
//   req_stall rises only once every stage is full.
//   Reset clears all valid bits; the pipeline comes out of reset empty.
//   A stalled response holds its data until taken.
module euler_angles_to_rotation_matrix #(
   parameter int CORDIC_STEPS = ear_pkg::CordicStepsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ear_pkg::ear_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ear_pkg::ear_rsp_type rsp_data
);

   // cap the cell count at the arctangent table length
   localparam int Steps  = (CORDIC_STEPS > ear_pkg::AtanLen) ? ear_pkg::AtanLen
                                                            : CORDIC_STEPS;
   localparam int Trig   = Steps + 1;     // sine/cosine stage index
   localparam int Last   = Steps + 4;     // output register index
   localparam int NStage = Steps + 5;

   logic [NStage-1:0] stage_valid;
   logic [NStage-1:0] ready;

   ear_pkg::ear_pipe_type pipe [Steps+1];
   ear_pkg::ear_pipe_type fold_ff, fold_in;
   ear_pkg::ear_trig_type trig_ff, trig_in;
   logic [2:0]            mat_valid;

   logic signed [15:0] angle [3];
   logic signed [34:0] zw    [3];
   logic signed [33:0] xf    [3];
   logic signed [33:0] yf    [3];
   logic signed [17:0] cs    [3];
   logic signed [17:0] sn    [3];
   logic signed [15:0] cos_q [3];
   logic signed [15:0] sin_q [3];

   // Ready chain: a stage loads when it is empty or its successor loads.
   assign ready[Last] = !stage_valid[Last] || !rsp_stall;
   for (genvar k = 0; k < Last; k++) begin : g_ready
      assign ready[k] = !stage_valid[k] || ready[k+1];
   end

   assign req_stall = !ready[0];

   // Fold the angle into [-pi/2, pi/2], remembering a half-turn flip.
   always_comb begin
      angle[0] = req_data.angle_x;
      angle[1] = req_data.angle_y;
      angle[2] = req_data.angle_z;
      fold_in.valid = req_valid;
      fold_in.kind  = req_data.kind;
      for (int l = 0; l < 3; l++) begin
         zw[l] = {{2{angle[l][15]}}, angle[l], 17'b0};
         fold_in.lane[l].x = ear_pkg::InvGain;
         fold_in.lane[l].y = 34'sd0;
         if (zw[l] > ear_pkg::HalfPi) begin
            zw[l]           = zw[l] - ear_pkg::Pi;
            fold_in.flip[l] = 1'b1;
         end else if (zw[l] < -ear_pkg::HalfPi) begin
            zw[l]           = zw[l] + ear_pkg::Pi;
            fold_in.flip[l] = 1'b1;
         end else begin
            fold_in.flip[l] = 1'b0;
         end
         fold_in.lane[l].z = zw[l][33:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff.valid <= 1'b0;
      end else if (ready[0]) begin
         fold_ff <= fold_in;
      end
   end

   assign pipe[0]        = fold_ff;
   assign stage_valid[0] = fold_ff.valid;

   // Row of CORDIC cells, one rotation step each.
   for (genvar s = 0; s < Steps; s++) begin : g_cell
      ear_cordic_cell #(
         .STEP (s)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (ready[s+1]),
         .prev_stage (pipe[s]),
         .next_stage (pipe[s+1])
      );
      assign stage_valid[s+1] = pipe[s+1].valid;
   end

   // Undo the flip, round Q30 to Q2.14 and saturate.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         xf[l]    = pipe[Steps].flip[l] ? -pipe[Steps].lane[l].x : pipe[Steps].lane[l].x;
         yf[l]    = pipe[Steps].flip[l] ? -pipe[Steps].lane[l].y : pipe[Steps].lane[l].y;
         cs[l]    = 18'((xf[l] + 34'sd32768) >>> 16);
         sn[l]    = 18'((yf[l] + 34'sd32768) >>> 16);
         cos_q[l] = ear_pkg::ear_clamp({{2{cs[l][17]}}, cs[l]});
         sin_q[l] = ear_pkg::ear_clamp({{2{sn[l][17]}}, sn[l]});
      end
      trig_in.valid = pipe[Steps].valid;
      trig_in.kind  = pipe[Steps].kind;
      trig_in.sx    = sin_q[0];
      trig_in.cx    = cos_q[0];
      trig_in.sy    = sin_q[1];
      trig_in.cy    = cos_q[1];
      trig_in.sz    = sin_q[2];
      trig_in.cz    = cos_q[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff.valid <= 1'b0;
      end else if (ready[Trig]) begin
         trig_ff <= trig_in;
      end
   end

   assign stage_valid[Trig] = trig_ff.valid;

   ear_matrix u_matrix (
      .clock   (clock),
      .reset   (reset),
      .advance (ready[Last:Trig+1]),
      .trig    (trig_ff),
      .valid   (mat_valid),
      .rsp     (rsp_data)
   );

   assign stage_valid[Last:Trig+1] = mat_valid;
   assign rsp_valid                = mat_valid[2];

endmodule

// ===== hdl/ear_checker.sv =====
// Port-level checks for the Euler-angle rotation matrix block, bound to the top level.
module ear_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input ear_pkg::ear_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ear_pkg::ear_rsp_type rsp_data
);

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Hold a stalled request.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // Come out of reset with an empty pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // An empty output lets every stage advance.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // Keep the diagonal entries within the unit range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.m00 <= 16384 && rsp_data.m00 >= -16384
                 && rsp_data.m11 <= 16384 && rsp_data.m11 >= -16384
                 && rsp_data.m22 <= 16384 && rsp_data.m22 >= -16384)
      else $error("matrix entry out of range");

endmodule

bind euler_angles_to_rotation_matrix ear_checker u_ear_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
